@@ hdl/hmq_pkg.sv @@
// Shared constants and types for the binary max-heap priority queue.
`default_nettype none
package hmq_pkg;

  localparam int CAPACITY = 64;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 1;
  localparam int VW = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_FIN,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ hdl/hmq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none
module hmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/binary_max_heap_queue.sv @@
// Top level of the binary max-heap priority queue.
//
// Channel   Signals                                   Handshake
// command   start, op, value                          accepted when start && !busy
// result    done, top_value, count, empty_res, error  one-cycle strobe on done
//
// Query, clear, pop of the last word and rejected operations raise done in the
// cycle after acceptance. Push reads the parent of the hole and moves it down while
// it is smaller than the new word, which is then written at its final place. Pop
// reads the last word into the root and at each level reads the left and then the
// right child, moving the larger one up while it beats the sinking word; the single
// read port of the heap memory makes the two child reads separate steps.
// Reset empties the queue at once. The result strobe cannot be stalled; busy stays
// high until its cycle ends.
`default_nettype none
module binary_max_heap_queue
  import hmq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         op,
  input  wire logic signed [31:0] value,
  output logic                    done,
  output logic signed [31:0]      top_value,
  output logic [6:0]              count,
  output logic                    empty_res,
  output logic [1:0]              error
);

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] pos, pos_next;
  logic signed [VW-1:0] val, val_next;
  logic signed [VW-1:0] ldata, ldata_next;
  logic signed [VW-1:0] top;
  err_t err, err_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rdata;

  logic          accept;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] parent;
  logic [IW-1:0] left;
  logic [IW-1:0] right;
  logic          right_ok;
  logic signed [VW-1:0] best_val;
  logic [AW-1:0] best_idx;
  logic          best_moved;

  hmq_ram #(
    .WIDTH(VW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign accept = start && !busy;
  assign pos_m1 = pos - AW'(1);
  assign parent = {1'b0, pos_m1[AW-1:1]};
  assign left   = {pos, 1'b1};
  assign right  = left + IW'(1);
  assign right_ok = right < IW'(cnt);

  // Pick the larger child; the left one wins ties and the sinking word wins
  // unless a child is strictly larger.
  always_comb begin
    best_val   = val;
    best_idx   = pos;
    best_moved = 1'b0;
    if (ldata > val) begin
      best_val   = ldata;
      best_idx   = left[AW-1:0];
      best_moved = 1'b1;
    end
    if (right_ok && ($signed(rdata) > best_val)) begin
      best_val   = $signed(rdata);
      best_idx   = right[AW-1:0];
      best_moved = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    val   <= val_next;
    ldata <= ldata_next;
    err   <= err_next;
    if (we && (waddr == '0)) begin
      top <= $signed(wdata);
    end
  end

  // The moving word stays in val and is written once at its final place;
  // each step moves one neighbor into the hole instead of swapping.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pos_next   = pos;
    val_next   = val;
    ldata_next = ldata;
    err_next   = err;
    we         = 1'b0;
    waddr      = pos;
    wdata      = val;
    raddr      = parent;
    busy       = (state != S_IDLE);
    done       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          err_next   = ERR_NONE;
          state_next = S_DONE;
          case (op_t'(op))
            OP_PUSH: begin
              if (cnt == CW'(CAPACITY)) begin
                err_next = ERR_FULL;
              end else begin
                val_next   = value;
                pos_next   = cnt[AW-1:0];
                cnt_next   = cnt + CW'(1);
                state_next = (cnt == '0) ? S_FIN : S_UP_RD;
              end
            end
            OP_POP: begin
              if (cnt == '0) begin
                err_next = ERR_EMPTY;
              end else begin
                cnt_next = cnt - CW'(1);
                if (cnt != CW'(1)) begin
                  state_next = S_DN_LAST;
                end
              end
            end
            OP_CLEAR: begin
              cnt_next = '0;
            end
            OP_QUERY: begin
              if (cnt == '0) begin
                err_next = ERR_EMPTY;
              end
            end
            default: begin
              err_next = ERR_NONE;
            end
          endcase
        end
      end
      S_UP_RD: begin
        raddr      = parent;
        state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if ($signed(rdata) < val) begin
          wdata      = rdata;
          pos_next   = parent;
          state_next = (parent == '0) ? S_FIN : S_UP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FIN: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_DN_LAST: begin
        raddr      = cnt[AW-1:0];
        state_next = S_DN_LOAD;
      end
      S_DN_LOAD: begin
        val_next   = $signed(rdata);
        pos_next   = '0;
        state_next = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left >= IW'(cnt)) begin
          we         = 1'b1;
          state_next = S_DONE;
        end else begin
          raddr      = left[AW-1:0];
          state_next = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        ldata_next = $signed(rdata);
        raddr      = right[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (best_moved) begin
          wdata      = best_val;
          pos_next   = best_idx;
          state_next = S_DN_RDL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign top_value = (cnt != '0) ? top : '0;
  assign count     = 7'(cnt);
  assign empty_res = (cnt == '0);
  assign error     = err;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> (state != S_IDLE) && (state != S_DONE))
    else $error("heap memory written outside an operation");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && (op_t'(op) == OP_CLEAR)) |=> done && empty_res && (error == ERR_NONE))
    else $error("clear did not empty the queue");

  a_full: assert property (@(posedge clk) disable iff (rst)
    (done && (error == ERR_FULL)) |-> (cnt == CW'(CAPACITY)))
    else $error("push rejected while the queue had room");
`endif

endmodule
`default_nettype wire

@@ tb/binary_max_heap_queue_tb.sv @@
// Self-checking testbench for the binary max-heap priority queue: directed table plus random traffic.
`default_nettype none
module binary_max_heap_queue_tb;
  import hmq_pkg::*;

  localparam int RANDOM_WORDS = 1000;
  localparam int unsigned RUN_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;

  typedef struct {
    logic signed [31:0] top;
    logic [6:0]         cnt;
    logic               empty;
    err_t               err;
  } heap_result_t;

  typedef struct {
    op_t                op;
    logic signed [31:0] val;
    bit                 fixed;
    heap_result_t       want;
  } cmd_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  op_t                op = OP_QUERY;
  logic signed [31:0] value = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] top_value;
  logic [6:0]         count;
  logic               empty_res;
  logic [1:0]         error;

  // Shadow copy of the heap that predicts every result not fixed by the directed table.
  logic signed [31:0] shadow_heap [CAPACITY];
  int                 shadow_fill = 0;

  heap_result_t       pending_results [$];
  heap_result_t       oldest;
  cmd_row_t           script [$];
  int                 mismatch_count = 0;
  int                 result_index = 0;
  int                 burst_left = 1;
  int                 words_sent = 0;
  int unsigned        cycle_count = 0;

  binary_max_heap_queue dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .value     (value),
    .done      (done),
    .top_value (top_value),
    .count     (count),
    .empty_res (empty_res),
    .error     (error)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("binary_max_heap_queue: mismatch");
    $finish;
  end

  task automatic predict_heap_op(input op_t o, input logic signed [31:0] v,
                                 output heap_result_t res);
    int pos;
    int parent;
    int best;
    int left;
    int right;
    logic signed [31:0] tmp;
    err_t err;
    err = ERR_NONE;
    case (o)
      OP_PUSH: begin
        if (shadow_fill >= CAPACITY) begin
          err = ERR_FULL;
        end else begin
          shadow_heap[shadow_fill] = v;
          shadow_fill++;
          // Climb only while the parent is strictly smaller.
          pos = shadow_fill - 1;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(shadow_heap[parent] < shadow_heap[pos])) break;
            tmp = shadow_heap[parent];
            shadow_heap[parent] = shadow_heap[pos];
            shadow_heap[pos] = tmp;
            pos = parent;
          end
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          err = ERR_EMPTY;
        end else begin
          shadow_fill--;
          shadow_heap[0] = shadow_heap[shadow_fill];
          // Sink toward a strictly larger child; the left one wins a tie.
          pos = 0;
          while (pos < shadow_fill) begin
            best = pos;
            left = 2 * pos + 1;
            right = left + 1;
            if (left < shadow_fill && shadow_heap[best] < shadow_heap[left]) best = left;
            if (right < shadow_fill && shadow_heap[best] < shadow_heap[right]) best = right;
            if (best == pos) break;
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[best];
            shadow_heap[best] = tmp;
            pos = best;
          end
        end
      end
      OP_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
        if (shadow_fill == 0) err = ERR_EMPTY;
      end
    endcase
    res.top = (shadow_fill != 0) ? shadow_heap[0] : '0;
    res.cnt = shadow_fill[6:0];
    res.empty = (shadow_fill == 0);
    res.err = err;
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken, or later after a random idle gap.
  task automatic send_word(input op_t o, input logic signed [31:0] v, input bit fixed,
                           input heap_result_t want);
    heap_result_t predicted;
    int gap;
    start <= 1'b1;
    op <= o;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_heap_op(o, v, predicted);
    pending_results.insert(pending_results.size(), fixed ? want : predicted);
    words_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if ($urandom_range(0, 15) == 0) gap = 60;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_all_results();
    if (start) start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] random_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $signed($urandom_range(0, 15)) - 32'sd8;
      1: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random(input op_t o);
    heap_result_t none;
    none = '{top: '0, cnt: '0, empty: 1'b0, err: ERR_NONE};
    send_word(o, random_value(), 1'b0, none);
  endtask

  task automatic fill_to_full();
    while (shadow_fill < CAPACITY) send_random(OP_PUSH);
    repeat ($urandom_range(1, 3)) send_random(OP_PUSH);
  endtask

  task automatic drain_to_empty();
    while (shadow_fill > 0) send_random(OP_POP);
    repeat ($urandom_range(1, 2)) send_random(($urandom_range(0, 1) == 0) ? OP_POP : OP_QUERY);
  endtask

  task automatic add_row(input op_t o, input logic signed [31:0] v, input bit fixed,
                         input logic signed [31:0] top, input logic [6:0] cnt,
                         input logic empty, input err_t err);
    cmd_row_t r;
    r.op = o;
    r.val = v;
    r.fixed = fixed;
    r.want = '{top: top, cnt: cnt, empty: empty, err: err};
    script.insert(script.size(), r);
  endtask

  // Each result word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      result_index++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing expected: top %0d count %0d empty %0b error %0d",
                   result_index, top_value, count, empty_res, error);
      end else begin
        oldest = pending_results.pop_front();
        if (top_value !== oldest.top || count !== oldest.cnt ||
            empty_res !== oldest.empty || error !== oldest.err) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d differs: expected top %0d count %0d empty %0b error %0d, got top %0d count %0d empty %0b error %0d",
                     result_index, oldest.top, oldest.cnt, oldest.empty, oldest.err,
                     top_value, count, empty_res, error);
        end
      end
    end
  end

  initial begin
    int r;
    int seg_len;
    int mode;
    op_t pick;

    // Empty queue, extremes, ties and the empty-queue errors.
    add_row(OP_QUERY, 32'sd0, 1, 32'sd0, 7'd0, 1'b1, ERR_EMPTY);
    add_row(OP_POP, 32'sd0, 1, 32'sd0, 7'd0, 1'b1, ERR_EMPTY);
    add_row(OP_CLEAR, -32'sd1, 1, 32'sd0, 7'd0, 1'b1, ERR_NONE);
    add_row(OP_PUSH, VAL_MIN, 1, VAL_MIN, 7'd1, 1'b0, ERR_NONE);
    add_row(OP_PUSH, VAL_MAX, 1, VAL_MAX, 7'd2, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'sd0, 1, VAL_MAX, 7'd3, 1'b0, ERR_NONE);
    add_row(OP_PUSH, -32'sd1, 1, VAL_MAX, 7'd4, 1'b0, ERR_NONE);
    add_row(OP_PUSH, VAL_MAX, 1, VAL_MAX, 7'd5, 1'b0, ERR_NONE);
    add_row(OP_POP, 32'sd0, 1, VAL_MAX, 7'd4, 1'b0, ERR_NONE);
    add_row(OP_POP, VAL_MAX, 1, 32'sd0, 7'd3, 1'b0, ERR_NONE);
    add_row(OP_QUERY, VAL_MIN, 1, 32'sd0, 7'd3, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'sd5, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'sd5, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'sd3, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'sd5, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_POP, 32'sd0, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_POP, 32'sd0, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_POP, 32'sd0, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'sh55555555, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_PUSH, 32'shAAAAAAAA, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_POP, 32'sd0, 0, '0, '0, 1'b0, ERR_NONE);
    add_row(OP_CLEAR, 32'sd0, 1, 32'sd0, 7'd0, 1'b1, ERR_NONE);
    add_row(OP_POP, 32'sd0, 1, 32'sd0, 7'd0, 1'b1, ERR_EMPTY);
    add_row(OP_QUERY, 32'sd0, 1, 32'sd0, 7'd0, 1'b1, ERR_EMPTY);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) send_word(script[i].op, script[i].val, script[i].fixed, script[i].want);
    wait_all_results();

    // Random traffic: mostly push-heavy and pop-heavy runs, with full fills and drains.
    fill_to_full();
    wait_all_results();
    drain_to_empty();
    while (words_sent < RANDOM_WORDS + script.size()) begin
      mode = $urandom_range(0, 9);
      seg_len = $urandom_range(1, 40);
      case (mode)
        0: fill_to_full();
        1: drain_to_empty();
        9: begin
          wait_all_results();
          if ($urandom_range(0, 1) == 0) send_random(OP_CLEAR);
        end
        default: begin
          repeat (seg_len) begin
            r = $urandom_range(0, 99);
            if (mode <= 4) begin
              pick = (r < 80) ? OP_PUSH : (r < 92) ? OP_POP : (r < 97) ? OP_QUERY : OP_CLEAR;
            end else if (mode <= 7) begin
              pick = (r < 20) ? OP_PUSH : (r < 90) ? OP_POP : (r < 97) ? OP_QUERY : OP_CLEAR;
            end else begin
              pick = op_t'($urandom_range(0, 3));
            end
            send_random(pick);
          end
        end
      endcase
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("binary_max_heap_queue: match");
    else
      $display("binary_max_heap_queue: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/hmq_pkg.sv
hdl/hmq_ram.sv
hdl/binary_max_heap_queue.sv
tb/binary_max_heap_queue_tb.sv
